>>> design/octagon_frame_pixel_shader_core_assert.svh
// ----------------------------------------------------------------------------
// Octagon frame pixel shader assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef OCTAGON_FRAME_PIXEL_SHADER_CORE_ASSERT_SVH
`define OCTAGON_FRAME_PIXEL_SHADER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define OFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define OFPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define OFPS_ASSERT(lbl, prop, msg)
`define OFPS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> design/ofps_pkg.sv
// ----------------------------------------------------------------------------
// Octagon frame pixel shader package
// Shared constants, codes and types for the shader core and its frame lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package ofps_pkg;

  localparam int FRAME_COUNT = 11;
  localparam int FRAME_IDX_W = 4;

  // Signed width of transformed and frame-relative coordinates
  localparam int COORD_W = 16;

  localparam logic [7:0] DIAG_Q8 = 8'd181;

  localparam logic [9:0]  CENTRE_X_RESET = 10'd120;
  localparam logic [9:0]  CENTRE_Y_RESET = 10'd120;
  localparam logic [10:0] SCALE_RESET    = 11'sd304;
  localparam logic [10:0] SHEAR_RESET    = 11'sd40;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_CENTRE_X = 2'd0,
    CFG_CENTRE_Y = 2'd1,
    CFG_SCALE_X  = 2'd2,
    CFG_SHEAR    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [9:0]        radius;
    logic [7:0]        half_width;
    logic signed [9:0] offset_x;
    logic signed [9:0] offset_y;
    logic [15:0]       core;
    logic [15:0]       glow_near;
    logic [15:0]       glow_far;
  } frame_entry_t;

  typedef struct packed {
    logic        stop;
    logic [15:0] colour;
  } lane_res_t;

endpackage

`default_nettype wire

>>> design/ofps_lane.sv
// ----------------------------------------------------------------------------
// Octagon frame lane
// Four-stage octagon norm and ring test of one pixel against one frame entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ofps_lane (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic signed [ofps_pkg::COORD_W-1:0]    tx_i,
  input  wire logic signed [ofps_pkg::COORD_W-1:0]    ty_i,
  input  wire ofps_pkg::frame_entry_t                 entry_i,
  output ofps_pkg::lane_res_t                         res_o
);

  logic signed [ofps_pkg::COORD_W-1:0] rel_x, rel_y;
  logic [ofps_pkg::COORD_W-2:0]        ax_d, ay_d, ax_q, ay_q;
  logic [ofps_pkg::COORD_W-1:0]        sum_d, sum_q;
  logic [ofps_pkg::COORD_W-2:0]        max_d, max_q;
  logic [ofps_pkg::COORD_W+7:0]        diag_prod;
  logic [ofps_pkg::COORD_W-1:0]        diag, norm_d, norm_q;
  logic [ofps_pkg::COORD_W-1:0]        rad, hw, ring_gap;
  ofps_pkg::lane_res_t                 res_d, res_q;

  // Stage A: offset and magnitude
  always_comb begin
    rel_x = tx_i - {{(ofps_pkg::COORD_W-10){entry_i.offset_x[9]}}, entry_i.offset_x};
    rel_y = ty_i - {{(ofps_pkg::COORD_W-10){entry_i.offset_y[9]}}, entry_i.offset_y};
    ax_d  = rel_x[ofps_pkg::COORD_W-1] ? (ofps_pkg::COORD_W-1)'(-rel_x)
                                       : rel_x[ofps_pkg::COORD_W-2:0];
    ay_d  = rel_y[ofps_pkg::COORD_W-1] ? (ofps_pkg::COORD_W-1)'(-rel_y)
                                       : rel_y[ofps_pkg::COORD_W-2:0];
  end

  // Stage B: sum and larger axis
  always_comb begin
    sum_d = {1'b0, ax_q} + {1'b0, ay_q};
    max_d = (ax_q > ay_q) ? ax_q : ay_q;
  end

  // Stage C: diagonal term and octagon norm
  always_comb begin
    diag_prod = {8'd0, sum_q} * {{ofps_pkg::COORD_W{1'b0}}, ofps_pkg::DIAG_Q8};
    diag      = diag_prod[ofps_pkg::COORD_W+7:8];
    norm_d    = (diag > {1'b0, max_q}) ? diag : {1'b0, max_q};
  end

  // Stage D: distance to the ring and color choice
  always_comb begin
    rad      = {{(ofps_pkg::COORD_W-10){1'b0}}, entry_i.radius};
    hw       = {{(ofps_pkg::COORD_W-8){1'b0}}, entry_i.half_width};
    ring_gap = (norm_q > rad) ? (norm_q - rad) : (rad - norm_q);
    res_d    = '0;
    if (ring_gap <= hw) begin
      res_d.stop   = 1'b1;
      res_d.colour = entry_i.core;
    end else if (ring_gap == hw + ofps_pkg::COORD_W'(1)) begin
      res_d.stop   = 1'b1;
      res_d.colour = entry_i.glow_near;
    end else if (ring_gap == hw + ofps_pkg::COORD_W'(2)) begin
      res_d.stop   = 1'b1;
      res_d.colour = entry_i.glow_far;
    end else begin
      // outside this ring: black ends the search, inside passes inward
      res_d.stop   = (norm_q >= rad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      sum_q  <= sum_d;
      max_q  <= max_d;
      norm_q <= norm_d;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> design/octagon_frame_pixel_shader_core.sv
// Throughput: one pixel per cycle; the eight-stage pipeline stalls as a whole
// when the output register is full and not taken.
// A load request waits until the pipeline has drained: it is taken only once
// the last pixel has been taken from the output register.
// Reset clears the valid bits and restores the configuration registers;
// ----------------------------------------------------------------------------
// Octagon frame pixel shader core
// Centers, scales and shears a pixel, tests it against eleven nested octagon
// frames in parallel lanes and picks the outermost frame that ends the search.
// The frame table holds no reset value and must be loaded before shading.
// ----------------------------------------------------------------------------
`default_nettype none

`include "octagon_frame_pixel_shader_core_assert.svh"

module octagon_frame_pixel_shader_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [10:0]                         cfg_data_i,
  // requests
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                req_type_i,
  input  wire logic [ofps_pkg::FRAME_IDX_W-1:0]    frame_index_i,
  input  wire logic [9:0]                          entry_radius_i,
  input  wire logic [7:0]                          entry_half_width_i,
  input  wire logic signed [9:0]                   entry_offset_x_i,
  input  wire logic signed [9:0]                   entry_offset_y_i,
  input  wire logic [15:0]                         entry_core_colour_i,
  input  wire logic [15:0]                         entry_glow_near_i,
  input  wire logic [15:0]                         entry_glow_far_i,
  input  wire logic [10:0]                         pixel_x_i,
  input  wire logic [10:0]                         pixel_y_i,
  // results
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [15:0]                              pixel_colour_o
);

  localparam int STAGES = 8;

  logic [9:0]          centre_x_q, centre_y_q;
  logic signed [10:0]  scale_q, shear_q;

  ofps_pkg::frame_entry_t entry_q [ofps_pkg::FRAME_COUNT];
  ofps_pkg::lane_res_t    lane_res [ofps_pkg::FRAME_COUNT];

  logic [STAGES-1:0]   vld_d, vld_q;
  logic                en, in_acc, is_pixel, is_load;

  logic signed [11:0]  dx_d, dy_d, dx_q, dy_q, dy2_q;
  logic signed [22:0]  px_d, ps_d, px_q, ps_q;
  logic signed [ofps_pkg::COORD_W-1:0] tx_d, ty_d, tx_q, ty_q;
  logic [15:0]         colour_d, colour_q;

  // ---------------------------------------------------------------- control
  assign en         = !vld_q[STAGES-1] || out_ready_i;
  assign is_pixel   = (req_type_i == ofps_pkg::REQ_PIXEL);
  assign is_load    = (req_type_i == ofps_pkg::REQ_LOAD);
  // hold a load until no pixel is still reading the frame table
  assign in_ready_o = en && (is_pixel || (vld_q == '0));
  assign in_acc     = in_valid_i && in_ready_o;

  assign vld_d = {vld_q[STAGES-2:0], in_acc && is_pixel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o    = vld_q[STAGES-1];
  assign pixel_colour_o = colour_q;

  // ---------------------------------------------------------- configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= ofps_pkg::CENTRE_X_RESET;
      centre_y_q <= ofps_pkg::CENTRE_Y_RESET;
      scale_q    <= ofps_pkg::SCALE_RESET;
      shear_q    <= ofps_pkg::SHEAR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ofps_pkg::CFG_CENTRE_X: centre_x_q <= cfg_data_i[9:0];
        ofps_pkg::CFG_CENTRE_Y: centre_y_q <= cfg_data_i[9:0];
        ofps_pkg::CFG_SCALE_X:  scale_q    <= cfg_data_i;
        ofps_pkg::CFG_SHEAR:    shear_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ frame table
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ofps_pkg::FRAME_COUNT; k++) begin
      if (in_acc && is_load && (frame_index_i == ofps_pkg::FRAME_IDX_W'(k))) begin
        entry_q[k].radius     <= entry_radius_i;
        entry_q[k].half_width <= entry_half_width_i;
        entry_q[k].offset_x   <= entry_offset_x_i;
        entry_q[k].offset_y   <= entry_offset_y_i;
        entry_q[k].core       <= entry_core_colour_i;
        entry_q[k].glow_near  <= entry_glow_near_i;
        entry_q[k].glow_far   <= entry_glow_far_i;
      end
    end
  end

  // ---------------------------------------------------- coordinate transform
  always_comb begin
    dx_d = $signed({1'b0, pixel_x_i}) - $signed({2'b00, centre_x_q});
    dy_d = $signed({1'b0, pixel_y_i}) - $signed({2'b00, centre_y_q});
    px_d = dx_q * scale_q;
    ps_d = dx_q * shear_q;
    // arithmetic shift by 8 floors the Q8 products
    tx_d = {px_q[22], px_q[22:8]};
    ty_d = {{(ofps_pkg::COORD_W-12){dy2_q[11]}}, dy2_q} + {ps_q[22], ps_q[22:8]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      px_q  <= px_d;
      ps_q  <= ps_d;
      dy2_q <= dy_q;
      tx_q  <= tx_d;
      ty_q  <= ty_d;
    end
  end

  // ------------------------------------------------------------ frame lanes
  for (genvar g = 0; g < ofps_pkg::FRAME_COUNT; g++) begin : g_lane
    ofps_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .tx_i    (tx_q),
      .ty_i    (ty_q),
      .entry_i (entry_q[g]),
      .res_o   (lane_res[g])
    );
  end

  // Outermost stopping lane wins; no stop means black
  always_comb begin
    colour_d = '0;
    for (int k = 0; k < ofps_pkg::FRAME_COUNT; k++) begin
      if (lane_res[k].stop) begin
        colour_d = lane_res[k].colour;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      colour_q <= colour_d;
    end
  end

  // ------------------------------------------------------------- assertions
  `OFPS_ASSERT(a_load_on_empty,
    (in_valid_i && in_ready_o && req_type_i == ofps_pkg::REQ_LOAD) |-> (vld_q == '0),
    "load request accepted while pixels are in flight")

  `OFPS_ASSERT(a_pixel_enters,
    (in_valid_i && in_ready_o && req_type_i == ofps_pkg::REQ_PIXEL) |=> vld_q[0],
    "accepted pixel did not enter the pipeline")

  `OFPS_ASSERT(a_stall_holds,
    (!en) |=> ($stable(vld_q) && $stable(colour_q)),
    "pipeline moved during a stall")

  `OFPS_ASSERT_ALWAYS(a_reset_idle,
    (!rst_ni) |=> (!out_valid_o && vld_q == '0),
    "valid bits set during reset")

endmodule

`default_nettype wire

>>> bench/octagon_frame_pixel_shader_core_tb.sv
// ----------------------------------------------------------------------------
// Octagon frame pixel shader core testbench
// Loads nested frame tables, shades aimed and random pixels under several
// transform settings and handshake pressures, and checks every color against
// a cycle-free model of the shader kept alongside the block.
// ----------------------------------------------------------------------------
module octagon_frame_pixel_shader_core_tb;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 190;

  typedef struct {
    ofps_pkg::req_type_e    kind;
    logic [3:0]             idx;
    ofps_pkg::frame_entry_t entry;
    logic [10:0]            px;
    logic [10:0]            py;
  } shade_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  ofps_pkg::cfg_reg_e cfg_index_i = ofps_pkg::CFG_CENTRE_X;
  logic [10:0]        cfg_data_i  = '0;

  logic                in_valid_i          = 1'b0;
  logic                in_ready_o;
  ofps_pkg::req_type_e req_type_i          = ofps_pkg::REQ_LOAD;
  logic [3:0]          frame_index_i       = '0;
  logic [9:0]          entry_radius_i      = '0;
  logic [7:0]          entry_half_width_i  = '0;
  logic signed [9:0]   entry_offset_x_i    = '0;
  logic signed [9:0]   entry_offset_y_i    = '0;
  logic [15:0]         entry_core_colour_i = '0;
  logic [15:0]         entry_glow_near_i   = '0;
  logic [15:0]         entry_glow_far_i    = '0;
  logic [10:0]         pixel_x_i           = '0;
  logic [10:0]         pixel_y_i           = '0;

  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] pixel_colour_o;

  // model state, updated as requests are accepted
  ofps_pkg::frame_entry_t frame_table [ofps_pkg::FRAME_COUNT];
  logic [9:0]         cur_centre_x;
  logic [9:0]         cur_centre_y;
  logic signed [10:0] cur_scale;
  logic signed [10:0] cur_shear;
  logic [15:0]        pending_colours [$];

  // what the stimulus side has loaded so far, used only to aim pixels
  ofps_pkg::frame_entry_t planned_frames [ofps_pkg::FRAME_COUNT];
  shade_req_t             pending_reqs [$];

  int  reqs_queued    = 0;
  int  reqs_accepted  = 0;
  int  mismatch_count = 0;
  int  stall_cycles   = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  req_fire = 1'b0;
  bit  cfg_fire = 1'b0;

  octagon_frame_pixel_shader_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .frame_index_i       (frame_index_i),
    .entry_radius_i      (entry_radius_i),
    .entry_half_width_i  (entry_half_width_i),
    .entry_offset_x_i    (entry_offset_x_i),
    .entry_offset_y_i    (entry_offset_y_i),
    .entry_core_colour_i (entry_core_colour_i),
    .entry_glow_near_i   (entry_glow_near_i),
    .entry_glow_far_i    (entry_glow_far_i),
    .pixel_x_i           (pixel_x_i),
    .pixel_y_i           (pixel_y_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pixel_colour_o      (pixel_colour_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Color of one pixel: walk the frames outermost first until one ends the search.
  function automatic logic [15:0] shade_pixel(input logic [10:0] px, input logic [10:0] py);
    longint      dx, dy, tx, ty, ax, ay, diag, peak;
    logic [15:0] norm;
    int          gap, hw, rad, k;
    logic [15:0] colour;
    bit          done;
    colour = '0;
    done   = 1'b0;
    dx = longint'(px) - longint'(cur_centre_x);
    dy = longint'(py) - longint'(cur_centre_y);
    tx = (dx * longint'(cur_scale)) >>> 8;
    ty = dy + ((dx * longint'(cur_shear)) >>> 8);
    for (k = ofps_pkg::FRAME_COUNT - 1; k >= 0 && !done; k--) begin
      ax = tx - longint'($signed(frame_table[k].offset_x));
      ay = ty - longint'($signed(frame_table[k].offset_y));
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      diag = ((ax + ay) * longint'(ofps_pkg::DIAG_Q8)) >>> 8;
      peak = (ax > ay) ? ax : ay;
      if (diag > peak) peak = diag;
      norm = peak[15:0];
      rad  = int'(frame_table[k].radius);
      hw   = int'(frame_table[k].half_width);
      gap  = (int'(norm) > rad) ? int'(norm) - rad : rad - int'(norm);
      if (gap <= hw) begin
        colour = frame_table[k].core;
        done   = 1'b1;
      end else if (gap == hw + 1) begin
        colour = frame_table[k].glow_near;
        done   = 1'b1;
      end else if (gap == hw + 2) begin
        colour = frame_table[k].glow_far;
        done   = 1'b1;
      end else if (int'(norm) >= rad) begin
        done = 1'b1;
      end
    end
    return colour;
  endfunction

  // Sample handshakes at the rising edge; predict, check and watch for a hang.
  always @(posedge clk_i) begin : monitor
    bit res_fire;
    if (!rst_ni) begin
      cur_centre_x = ofps_pkg::CENTRE_X_RESET;
      cur_centre_y = ofps_pkg::CENTRE_Y_RESET;
      cur_scale    = ofps_pkg::SCALE_RESET;
      cur_shear    = ofps_pkg::SHEAR_RESET;
      req_fire     = 1'b0;
      cfg_fire     = 1'b0;
    end else begin
      cfg_fire = cfg_valid_i && cfg_ready_o;
      req_fire = in_valid_i && in_ready_o;
      res_fire = out_valid_o && out_ready_i;
      if (cfg_fire) begin
        case (cfg_index_i)
          ofps_pkg::CFG_CENTRE_X: cur_centre_x = cfg_data_i[9:0];
          ofps_pkg::CFG_CENTRE_Y: cur_centre_y = cfg_data_i[9:0];
          ofps_pkg::CFG_SCALE_X:  cur_scale    = cfg_data_i;
          ofps_pkg::CFG_SHEAR:    cur_shear    = cfg_data_i;
          default: ;
        endcase
      end
      if (res_fire) begin
        if (pending_colours.size() == 0) begin
          flag_error($sformatf("color %h with no request waiting", pixel_colour_o));
        end else if (pixel_colour_o !== pending_colours[0]) begin
          flag_error($sformatf("pixel color %h, expected %h", pixel_colour_o,
                               pending_colours[0]));
          void'(pending_colours.pop_front());
        end else begin
          void'(pending_colours.pop_front());
        end
      end
      if (req_fire) begin
        reqs_accepted++;
        if (req_type_i == ofps_pkg::REQ_LOAD) begin
          // out-of-range entries are dropped by the block
          if (frame_index_i < ofps_pkg::FRAME_COUNT) begin
            frame_table[frame_index_i] = '{radius: entry_radius_i,
                                           half_width: entry_half_width_i,
                                           offset_x: entry_offset_x_i,
                                           offset_y: entry_offset_y_i,
                                           core: entry_core_colour_i,
                                           glow_near: entry_glow_near_i,
                                           glow_far: entry_glow_far_i};
          end
        end else begin
          pending_colours.push_back(shade_pixel(pixel_x_i, pixel_y_i));
        end
      end
      if (cfg_fire || req_fire || res_fire) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // Present requests from the queue at the falling edge; hold until taken.
  always @(negedge clk_i) begin : req_driver
    shade_req_t next_req;
    if (rst_ni) begin
      if (!in_valid_i || req_fire) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid_i          <= 1'b1;
          req_type_i          <= next_req.kind;
          frame_index_i       <= next_req.idx;
          entry_radius_i      <= next_req.entry.radius;
          entry_half_width_i  <= next_req.entry.half_width;
          entry_offset_x_i    <= next_req.entry.offset_x;
          entry_offset_y_i    <= next_req.entry.offset_y;
          entry_core_colour_i <= next_req.entry.core;
          entry_glow_near_i   <= next_req.entry.glow_near;
          entry_glow_far_i    <= next_req.entry.glow_far;
          pixel_x_i           <= next_req.px;
          pixel_y_i           <= next_req.py;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic shade_req_t rand_req();
    shade_req_t  r;
    logic [95:0] raw;
    raw     = {$urandom, $urandom, $urandom};
    r.kind  = ofps_pkg::req_type_e'($urandom_range(0, 1));
    r.idx   = 4'($urandom_range(0, 15));
    r.entry = raw[85:0];
    r.px    = 11'($urandom_range(0, 2047));
    r.py    = 11'($urandom_range(0, 2047));
    return r;
  endfunction

  task automatic queue_req(input shade_req_t r);
    if (r.kind == ofps_pkg::REQ_LOAD && r.idx < ofps_pkg::FRAME_COUNT) begin
      planned_frames[r.idx] = r.entry;
    end
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic queue_load(input int k, input ofps_pkg::frame_entry_t e);
    shade_req_t r;
    r       = rand_req();
    r.kind  = ofps_pkg::REQ_LOAD;
    r.idx   = 4'(k);
    r.entry = e;
    queue_req(r);
  endtask

  // Load a nested set: radii grow with the index, centers mostly stay close.
  task automatic queue_frame_set();
    shade_req_t r;
    int         ring, k;
    ring = 0;
    for (k = 0; k < ofps_pkg::FRAME_COUNT; k++) begin
      r = rand_req();
      ring += ($urandom_range(0, 15) == 0) ? $urandom_range(60, 300) : $urandom_range(4, 50);
      r.entry.radius     = (ring > 1023) ? 10'd1023 : 10'(ring);
      r.entry.half_width = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) begin
        r.entry.offset_x = 10'(int'($urandom_range(0, 16)) - 8);
        r.entry.offset_y = 10'(int'($urandom_range(0, 16)) - 8);
      end
      queue_load(k, r.entry);
    end
  endtask

  // Aim a pixel at distance radius+delta from the center of frame k in
  // transformed space, then undo the scale and shear to find screen coordinates.
  task automatic queue_aimed(input int k, input int delta);
    shade_req_t r;
    int len, perp, rx, ry, tx, ty, dx, dy, cx, cy, scale, shear;
    r     = rand_req();
    r.kind = ofps_pkg::REQ_PIXEL;
    cx    = int'(cur_centre_x);
    cy    = int'(cur_centre_y);
    scale = int'(cur_scale);
    shear = int'(cur_shear);
    len   = int'(planned_frames[k].radius) + delta;
    if (len < 0) len = -len;
    perp  = int'($urandom_range(0, len / 2)) - len / 4;
    case ($urandom_range(0, 3))
      0: begin rx = len;  ry = perp; end
      1: begin rx = -len; ry = perp; end
      2: begin rx = perp; ry = len;  end
      default: begin rx = perp; ry = -len; end
    endcase
    tx = int'($signed(planned_frames[k].offset_x)) + rx;
    ty = int'($signed(planned_frames[k].offset_y)) + ry;
    if (scale == 0) dx = int'($urandom_range(0, 2047)) - cx;
    else dx = (tx * 256) / scale;
    dy = ty - ((dx * shear) >>> 8);
    r.px = 11'(cx + dx);
    r.py = 11'(cy + dy);
    queue_req(r);
  endtask

  task automatic queue_pixel(input logic [10:0] px, input logic [10:0] py);
    shade_req_t r;
    r      = rand_req();
    r.kind = ofps_pkg::REQ_PIXEL;
    r.px   = px;
    r.py   = py;
    queue_req(r);
  endtask

  task automatic write_reg(input ofps_pkg::cfg_reg_e idx, input logic [10:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every request is taken and every color is back, then let
  // the pipeline settle.
  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || pending_colours.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [9:0] cx, input logic [9:0] cy,
                           input logic [10:0] scale, input logic [10:0] shear,
                           input int send_idle, input int recv_stall, input int n_items);
    shade_req_t r;
    int i, pick, k, hw;
    wait_drained();
    write_reg(ofps_pkg::CFG_CENTRE_X, {1'b0, cx});
    write_reg(ofps_pkg::CFG_CENTRE_Y, {1'b0, cy});
    write_reg(ofps_pkg::CFG_SCALE_X, scale);
    write_reg(ofps_pkg::CFG_SHEAR, shear);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    queue_frame_set();
    for (i = ofps_pkg::FRAME_COUNT; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // load to a nonexistent entry: must leave the table alone
        r      = rand_req();
        r.kind = ofps_pkg::REQ_LOAD;
        r.idx  = 4'($urandom_range(ofps_pkg::FRAME_COUNT, 15));
        queue_req(r);
      end else if (pick < 5) begin
        r = rand_req();
        queue_load(int'($urandom_range(0, ofps_pkg::FRAME_COUNT - 1)), r.entry);
      end else if (pick < 20) begin
        queue_pixel(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      end else begin
        k  = $urandom_range(0, ofps_pkg::FRAME_COUNT - 1);
        hw = int'(planned_frames[k].half_width) + 4;
        queue_aimed(k, int'($urandom_range(0, 2 * hw)) - hw);
      end
    end
  endtask

  initial begin : stimulus
    shade_req_t r;
    int k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a full table with extreme fields, ignored loads, then
    // corners, the center and pixels on, beside and past one frame line.
    for (k = 0; k < ofps_pkg::FRAME_COUNT; k++) begin
      r = rand_req();
      r.entry.radius     = (k == 10) ? 10'd1023 : (k == 0) ? 10'd0 : 10'(20 * k + 5);
      r.entry.half_width = (k == 10) ? 8'd255 : 8'(k % 3);
      r.entry.offset_x   = (k == 9) ? -10'sd512 : (k == 8) ? 10'sd511 : 10'(k - 5);
      r.entry.offset_y   = (k == 9) ? 10'sd511 : (k == 8) ? -10'sd512 : 10'(5 - k);
      if (k == 1) r.entry.core = 16'h0000;
      if (k == 2) r.entry.core = 16'hFFFF;
      if (k == 3) begin
        r.entry.glow_near = 16'h0000;
        r.entry.glow_far  = 16'hFFFF;
      end
      queue_load(k, r.entry);
    end
    r = rand_req();
    r.kind = ofps_pkg::REQ_LOAD;
    r.idx  = 4'(ofps_pkg::FRAME_COUNT);
    queue_req(r);
    r.idx  = 4'd15;
    queue_req(r);
    queue_pixel(11'd0, 11'd0);
    queue_pixel(11'd2047, 11'd2047);
    queue_pixel(11'd0, 11'd2047);
    queue_pixel(11'd2047, 11'd0);
    queue_pixel(11'd120, 11'd120);
    queue_aimed(3, 0);
    queue_aimed(3, 1);
    queue_aimed(3, 2);
    queue_aimed(3, 3);
    queue_aimed(3, -1);

    // 11'h400 is -1024, 11'h3FF is 1023, 11'h700 is -256
    run_phase(10'd120,  10'd120,  11'd256,  11'd0,    0,  0,  PHASE_ITEMS);
    run_phase(10'd0,    10'd0,    11'h3FF,  11'h400,  85, 0,  PHASE_ITEMS);
    run_phase(10'd1023, 10'd1023, 11'h400,  11'h3FF,  0,  85, PHASE_ITEMS);
    run_phase(10'd512,  10'd300,  11'h700,  11'd0,    33, 33, PHASE_ITEMS);
    run_phase(10'd200,  10'd700,  11'd0,    11'd100,  0,  0,  PHASE_ITEMS);
    run_phase(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
              11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
              85, 0, PHASE_ITEMS);
    run_phase(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
              11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
              0, 85, PHASE_ITEMS);
    run_phase(10'd120,  10'd120,  11'd304,  11'd40,   33, 33, PHASE_ITEMS);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ofps_pkg.sv
design/ofps_lane.sv
design/octagon_frame_pixel_shader_core.sv
bench/octagon_frame_pixel_shader_core_tb.sv
